### hdl/mi_pkg.sv
// Shared types, widths and operation codes for the modular inverse unit.
`default_nettype none

package mi_pkg;

  // Operand width of the datapath; the channel fields stay 32 bits.
  localparam int WIDTH = 32;
  localparam int FIELD_W = 32;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [WIDTH:0]   ext_t;
  typedef logic [FIELD_W-1:0] field_t;

  // Shared add/subtract unit operation codes.
  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

  typedef struct packed {
    alu_op_t op;
    ext_t    x;
    ext_t    y;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  typedef struct packed {
    field_t modulus;
    field_t value;
  } operands_t;

  typedef struct packed {
    field_t inverse;
    logic   exists;
  } result_t;

endpackage

`default_nettype wire

### hdl/modular_inverse_unit.sv
// Top level: modular inverse by extended Euclid, with request and result channels.
//
//   channel   | direction | handshake                      | payload
//   operands  | in        | operands_valid / operands_stall | modulus, value
//   result    | out       | result_valid / result_stall     | inverse, exists
//
// One request at a time. A request with value 1, or a zero operand, goes straight
// to the done state; otherwise the loop runs one compare, modular doubling or
// subtraction per cycle on the single shared add/subtract unit. Synchronous
// active-high reset idles the loop and empties the result register. A finished
// result waits in the output register while result_stall is high, and the next
// request is taken meanwhile.
`default_nettype none

module modular_inverse_unit (
  input  logic              clk,
  input  logic              rst,
  input  mi_pkg::operands_t operands,
  input  logic              operands_valid,
  output logic              operands_stall,
  output mi_pkg::result_t   result,
  output logic              result_valid,
  input  logic              result_stall
);
  import mi_pkg::*;

  core_status_t core_status;
  word_t        core_inverse;
  logic         core_exists;
  logic         core_start;
  logic         core_take;
  result_t      result_r;

  // Accept a request only while the loop is idle.
  assign operands_stall = core_status.busy;
  assign core_start     = operands_valid & ~core_status.busy;

  // Move a finished result out once the output register is free.
  assign core_take = core_status.done & (~result_valid | ~result_stall);

  mi_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (core_start),
    .modulus (word_t'(operands.modulus)),
    .value   (word_t'(operands.value)),
    .take    (core_take),
    .status  (core_status),
    .inverse (core_inverse),
    .exists  (core_exists)
  );

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (core_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      result_r.inverse <= field_t'(core_inverse);
      result_r.exists  <= core_exists;
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire

### hdl/mi_alu.sv
// Shared add/subtract unit with borrow output, one operation per cycle.
`default_nettype none

module mi_alu (
  input  mi_pkg::alu_req_t req,
  output mi_pkg::ext_t     sum,
  output logic             borrow
);
  import mi_pkg::*;

  logic [WIDTH+1:0] total;

  // Subtract as add of the inverted operand plus one; carry out clear means borrow.
  always_comb begin
    if (req.op == ALU_SUB) begin
      total = {1'b0, req.x} + {1'b0, ~req.y} + (WIDTH+2)'(1);
    end else begin
      total = {1'b0, req.x} + {1'b0, req.y};
    end
  end

  assign sum    = total[WIDTH:0];
  assign borrow = (req.op == ALU_SUB) & ~total[WIDTH+1];

endmodule

`default_nettype wire

### hdl/mi_core.sv
// Sequencer and operand registers for the shift-subtract extended Euclid loop.
`default_nettype none

module mi_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mi_pkg::word_t        modulus,
  input  mi_pkg::word_t        value,
  input  logic                 take,
  output mi_pkg::core_status_t status,
  output mi_pkg::word_t        inverse,
  output logic                 exists
);
  import mi_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TEST  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_DBL   = 3'd3;
  localparam logic [2:0] ST_SUBR  = 3'd4;
  localparam logic [2:0] ST_SUBT  = 3'd5;
  localparam logic [2:0] ST_FIX   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state;
  // Remainders a, b with cofactors ta, tb: ta*value == a and tb*value == b mod m.
  word_t a, b, ta, tb;
  // Shifted divisor and its cofactor.
  word_t s, ts;
  word_t mod_r;

  alu_req_t alu_req;
  ext_t     alu_sum;
  logic     alu_borrow;

  mi_alu u_alu (
    .req    (alu_req),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  // Select the operation of the shared unit for the current step.
  always_comb begin
    unique case (state)
      ST_TEST:  alu_req = '{op: ALU_SUB, x: {1'b0, a},  y: {1'b0, b}};
      ST_SHIFT: alu_req = '{op: ALU_SUB, x: {1'b0, a},  y: {s, 1'b0}};
      ST_DBL:   alu_req = '{op: ALU_SUB, x: {ts, 1'b0}, y: {1'b0, mod_r}};
      ST_SUBR:  alu_req = '{op: ALU_SUB, x: {1'b0, a},  y: {1'b0, s}};
      ST_SUBT:  alu_req = '{op: ALU_SUB, x: {1'b0, ta}, y: {1'b0, ts}};
      ST_FIX:   alu_req = '{op: ALU_ADD, x: {1'b0, ta}, y: {1'b0, mod_r}};
      default:  alu_req = '{op: ALU_ADD, x: '0, y: '0};
    endcase
  end

  // Advance the loop: swap when a < b, scale a copy of b up, subtract, fix cofactor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            mod_r <= modulus;
            priority if (value == word_t'(1)) begin
              a     <= word_t'(1);
              ta    <= word_t'(1);
              state <= ST_DONE;
            end else if (modulus == '0 || value == '0) begin
              a     <= '0;
              ta    <= '0;
              state <= ST_DONE;
            end else begin
              a     <= modulus;
              b     <= value;
              ta    <= '0;
              tb    <= (modulus == word_t'(1)) ? '0 : word_t'(1);
              state <= ST_TEST;
            end
          end
        end
        ST_TEST: begin
          priority if (b == '0) begin
            state <= ST_DONE;
          end else if (alu_borrow) begin
            a  <= b;
            b  <= a;
            ta <= tb;
            tb <= ta;
          end else begin
            s     <= b;
            ts    <= tb;
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (!alu_borrow) begin
            s     <= {s[WIDTH-2:0], 1'b0};
            state <= ST_DBL;
          end else begin
            state <= ST_SUBR;
          end
        end
        ST_DBL: begin
          ts    <= alu_borrow ? {ts[WIDTH-2:0], 1'b0} : alu_sum[WIDTH-1:0];
          state <= ST_SHIFT;
        end
        ST_SUBR: begin
          a     <= alu_sum[WIDTH-1:0];
          state <= ST_SUBT;
        end
        ST_SUBT: begin
          ta    <= alu_sum[WIDTH-1:0];
          state <= alu_borrow ? ST_FIX : ST_TEST;
        end
        ST_FIX: begin
          ta    <= alu_sum[WIDTH-1:0];
          state <= ST_TEST;
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The loop leaves the gcd in a and its cofactor in ta.
  assign exists      = (a == word_t'(1));
  assign inverse     = exists ? ta : '0;
  assign status.busy = (state != ST_IDLE);
  assign status.done = (state == ST_DONE);

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE)
    else $error("new operands started while loop busy");

  a_shift_fits: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> (s <= a) && (s != '0))
    else $error("shifted divisor exceeds remainder");

  a_cofactor_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_TEST |-> (ta < mod_r) && (tb < mod_r))
    else $error("cofactor not reduced modulo m");

  a_double_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DBL |=> ts < mod_r)
    else $error("modular doubling out of range");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for modular_inverse_unit with a scoreboard and randomized traffic.
`default_nettype none

module tb_top;
  import mi_pkg::*;

  // Cycles with no accepted request or result before the run is abandoned
  localparam int IDLE_LIMIT = 20000;
  localparam int PRINT_CAP = 40;
  localparam int DIRECTED_COUNT = 22;
  localparam int RANDOM_COUNT = 1080;
  localparam int DRAIN_EVERY = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam field_t BIG_PRIME = 32'hFFFF_FFFB;

  // Scoreboard: predicts the inverse of each accepted request and checks results in order
  class inverse_scoreboard;
    result_t pending_inverses[$];
    int errors;
    int requests_seen;
    int results_seen;
    int inverses_found;

    function new();
      errors = 0;
      requests_seen = 0;
      results_seen = 0;
      inverses_found = 0;
    endfunction

    function int pending();
      return pending_inverses.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Extended Euclid on 64-bit copies, cofactor kept reduced modulo m
    function result_t predict_inverse(input operands_t req);
      logic [63:0] m, n, rem_a, rem_b, cof_a, cof_b, quo, rem_next, step, cof_next;
      result_t res;
      m = 64'(req.modulus);
      n = 64'(req.value);
      res.inverse = '0;
      res.exists = 1'b0;
      if (n == 64'd1) begin
        res.inverse = field_t'(1);
        res.exists = 1'b1;
      end else if (m != 64'd0 && n != 64'd0) begin
        rem_a = m;
        rem_b = n % m;
        cof_a = 64'd0;
        cof_b = 64'd1 % m;
        while (rem_b != 64'd0) begin
          quo = rem_a / rem_b;
          rem_next = rem_a - quo * rem_b;
          step = ((quo % m) * cof_b) % m;
          cof_next = (cof_a + m - step) % m;
          rem_a = rem_b;
          rem_b = rem_next;
          cof_a = cof_b;
          cof_b = cof_next;
        end
        if (rem_a == 64'd1) begin
          res.inverse = cof_a[FIELD_W-1:0];
          res.exists = 1'b1;
        end
      end
      return res;
    endfunction

    function void note_request(input operands_t req);
      requests_seen++;
      pending_inverses.push_back(predict_inverse(req));
    endfunction

    task check_result(input result_t got);
      result_t want;
      results_seen++;
      if (pending_inverses.size() == 0) begin
        report_mismatch($sformatf("unexpected result inverse=%h exists=%b",
                                  got.inverse, got.exists));
      end else begin
        want = pending_inverses.pop_front();
        if (want.exists) inverses_found++;
        if (got.inverse !== want.inverse)
          report_mismatch($sformatf("inverse got %h expected %h", got.inverse, want.inverse));
        if (got.exists !== want.exists)
          report_mismatch($sformatf("exists got %b expected %b", got.exists, want.exists));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  operands_t operands;
  logic operands_valid;
  logic operands_stall;
  result_t result;
  logic result_valid;
  logic result_stall = 1'b0;

  inverse_scoreboard sb = new();
  int idle_cycles;
  int burst_left;
  int stall_mode;
  int stall_left;

  modular_inverse_unit DUT (
    .clk(clk),
    .rst(rst),
    .operands(operands),
    .operands_valid(operands_valid),
    .operands_stall(operands_stall),
    .result(result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result channel in phases: free, light, heavy, solid early in the phase
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(1, 40);
        result_stall <= 1'b0;
      end else begin
        stall_left <= stall_left - 1;
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= (stall_left > 24);
        endcase
      end
    end
  end

  // Monitor both channels and run the idle watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (operands_valid && !operands_stall) sb.note_request(operands);
      if (result_valid && !result_stall) sb.check_result(result);
      if ((operands_valid && !operands_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, sb.pending());
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one request, hold it until accepted, then maybe leave a gap
  task send_request(input field_t modulus, input field_t value);
    int gap;
    operands <= '{modulus: modulus, value: value};
    operands_valid <= 1'b1;
    @(posedge clk);
    while (operands_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (gap > 0) begin
        operands_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and hold off until every predicted result has been checked
  task wait_for_results();
    operands_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    field_t m;
    field_t n;
    field_t k;
    int kind;
    rst <= 1'b1;
    operands <= '0;
    operands_valid <= 1'b0;
    burst_left = 4;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: value one, zero operands, shared factors, modulus one, reduction, extremes
    send_request(32'd0, 32'd1);
    send_request(32'd1, 32'd1);
    send_request(32'hFFFF_FFFF, 32'd1);
    send_request(32'd0, 32'd5);
    send_request(32'd0, 32'd0);
    send_request(32'd17, 32'd0);
    send_request(32'hFFFF_FFFF, 32'd0);
    send_request(32'd12, 32'd8);
    send_request(32'd1, 32'd7);
    send_request(32'd1, 32'hFFFF_FFFF);
    send_request(32'd7, 32'd10);
    send_request(32'd7, 32'd7);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_request(BIG_PRIME, 32'd2);
    send_request(BIG_PRIME, BIG_PRIME - 32'd1);
    send_request(32'd2, 32'hFFFF_FFFF);
    send_request(32'h8000_0000, 32'd3);
    send_request(32'h8000_0000, 32'h8000_0001);
    send_request(32'd3, 32'd2);
    send_request(32'd10, 32'd3);
    send_request(32'hFFFF_FFFF, 32'h8000_0000);
    wait_for_results();

    // Random: mostly coprime-prone operands, plus shared factors, small moduli and corners
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      kind = $urandom_range(0, 9);
      m = $urandom;
      n = $urandom;
      case (kind)
        4: m = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 255) : $urandom_range(2, 65535);
        5: begin
          m = m | 32'd1;
          n = n % m;
        end
        6: begin
          k = $urandom_range(2, 255);
          m = field_t'($urandom_range(1, 65535)) * k;
          n = field_t'($urandom_range(0, 65535)) * k;
        end
        7: begin
          case ($urandom_range(0, 3))
            0: n = 32'd1;
            1: m = 32'd0;
            2: n = 32'd0;
            default: m = 32'd1;
          endcase
        end
        8: m = BIG_PRIME;
        9: n = m + field_t'($urandom_range(0, 2)) - 32'd1;
        default: ;
      endcase
      send_request(m, n);
      if ((i + 1) % DRAIN_EVERY == 0) wait_for_results();
    end

    // Let the pipeline empty, then settle
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    $display("Covered %0d requests (%0d directed corners), %0d results checked",
             sb.requests_seen, DIRECTED_COUNT, sb.results_seen);
    $display("Results with an inverse: %0d, without: %0d, mismatches: %0d",
             sb.inverses_found, sb.results_seen - sb.inverses_found, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
